// ----- rtl/isotp_frame_reassembler_assert.svh -----
// Assertion macros for the ISO-TP frame reassembler.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ISOTP_FRAME_REASSEMBLER_ASSERT_SVH
`define ISOTP_FRAME_REASSEMBLER_ASSERT_SVH
`ifndef SYNTH
`define ISOTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ISOTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ISOTP_ASSERT_IMP(label, ante, cons, msg)
`define ISOTP_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/isotp_pkg.sv -----
// Shared constants, transaction types and helper functions for the ISO-TP reassembler.
// No dependencies.
package isotp_pkg;

  localparam int MAX_LEN     = 512;
  localparam int STORE_WORDS = (MAX_LEN + 7) / 8;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int POS_W       = $clog2(MAX_LEN) + 1;
  localparam int LEN_W       = 12;
  localparam int CF_BYTES    = 7;
  localparam int FF_BYTES    = 6;
  localparam int CMDQ_DEPTH  = 4;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_FLOW     = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;

  localparam logic [3:0] FT_SINGLE = 4'h0;
  localparam logic [3:0] FT_FIRST  = 4'h1;
  localparam logic [3:0] FT_CONSEC = 4'h2;
  localparam logic [3:0] FT_FLOW   = 4'h3;

  typedef enum logic [1:0] {
    CMD_REPORT     = 2'd0,
    CMD_STORE      = 2'd1,
    CMD_STORE_LAST = 2'd2
  } cmd_op_t;

  typedef struct packed {
    logic [10:0] can_id;
    logic [63:0] payload;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [63:0]      data_word;
    logic [3:0]       valid_bytes;
    logic             last;
    logic [LEN_W-1:0] msg_length;
    logic [1:0]       flow_status;
    logic [7:0]       block_size;
    logic [7:0]       st_min;
  } out_t;

  // For store commands res carries top-aligned bytes and byte count; CMD_STORE_LAST also carries the message length.
  typedef struct packed {
    cmd_op_t          op;
    logic [POS_W-1:0] pos;
    out_t             res;
  } cmd_t;

  function automatic logic [63:0] top_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[63-8*i -: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [7:0] top_be(input logic [3:0] n);
    logic [7:0] be;
    be = '0;
    for (int i = 0; i < 8; i++) begin
      be[7-i] = (4'(i) < n);
    end
    return be;
  endfunction

endpackage

// ----- rtl/isotp_front.sv -----
// Front end: identifier filter, PCI decode and reassembly bookkeeping.
// Depends on isotp_pkg; feeds commands to isotp_cmdq.
module isotp_front import isotp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [10:0]      rx_id_r;
  logic             asm_r, asm_nxt;
  logic [POS_W-1:0] exp_r, exp_nxt;
  logic [POS_W-1:0] rc_r, rc_nxt;
  logic [3:0]       seq_r, seq_nxt;

  logic             accept;
  logic             match;
  logic             gen;
  logic [3:0]       ftype;
  logic [3:0]       low;
  logic [7:0]       b1;
  logic [11:0]      total;
  logic [POS_W-1:0] rc_sum;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign ftype    = in_data.payload[63:60];
  assign low      = in_data.payload[59:56];
  assign b1       = in_data.payload[55:48];
  assign total    = {low, b1};
  assign match    = (in_data.can_id == rx_id_r);
  assign rc_sum   = rc_r + POS_W'(CF_BYTES);
  assign q_push   = accept && match && gen;

  always_comb begin
    gen     = 1'b0;
    q_cmd   = '0;
    asm_nxt = asm_r;
    exp_nxt = exp_r;
    rc_nxt  = rc_r;
    seq_nxt = seq_r;
    unique case (ftype)
      FT_SINGLE: begin
        if (low != 4'd0 && low <= 4'd7) begin
          gen                   = 1'b1;
          q_cmd.op              = CMD_REPORT;
          q_cmd.res.kind        = KIND_DATA;
          q_cmd.res.data_word   = (in_data.payload << 8) & top_mask(low);
          q_cmd.res.valid_bytes = low;
          q_cmd.res.last        = 1'b1;
          q_cmd.res.msg_length  = LEN_W'(low);
        end
      end
      FT_FIRST: begin
        if ({1'b0, total} > 13'(MAX_LEN)) begin
          gen                  = 1'b1;
          q_cmd.op             = CMD_REPORT;
          q_cmd.res.kind       = KIND_TOO_LONG;
          q_cmd.res.last       = 1'b1;
          q_cmd.res.msg_length = total;
          asm_nxt              = 1'b0;
        end else if (total >= 12'd8) begin
          gen                   = 1'b1;
          q_cmd.op              = CMD_STORE;
          q_cmd.pos             = '0;
          q_cmd.res.data_word   = in_data.payload << 16;
          q_cmd.res.valid_bytes = 4'(FF_BYTES);
          asm_nxt               = 1'b1;
          exp_nxt               = POS_W'(total);
          rc_nxt                = POS_W'(FF_BYTES);
          seq_nxt               = 4'd0;
        end
      end
      FT_CONSEC: begin
        if (asm_r && low == 4'(seq_r + 4'd1)) begin
          gen                   = 1'b1;
          seq_nxt               = low;
          q_cmd.pos             = rc_r;
          q_cmd.res.data_word   = in_data.payload << 8;
          q_cmd.res.valid_bytes = 4'(CF_BYTES);
          if (rc_sum >= exp_r) begin
            q_cmd.op             = CMD_STORE_LAST;
            q_cmd.res.msg_length = LEN_W'(exp_r);
            asm_nxt              = 1'b0;
            exp_nxt              = '0;
            rc_nxt               = '0;
            seq_nxt              = 4'd0;
          end else begin
            q_cmd.op = CMD_STORE;
            rc_nxt   = rc_sum;
          end
        end
      end
      FT_FLOW: begin
        gen                   = 1'b1;
        q_cmd.op              = CMD_REPORT;
        q_cmd.res.kind        = KIND_FLOW;
        q_cmd.res.last        = 1'b1;
        q_cmd.res.flow_status = (low > 4'd3) ? 2'd3 : low[1:0];
        q_cmd.res.block_size  = b1;
        q_cmd.res.st_min      = in_data.payload[47:40];
      end
      default: begin
        gen = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_id_r <= '0;
      asm_r   <= 1'b0;
      exp_r   <= '0;
      rc_r    <= '0;
      seq_r   <= '0;
    end else begin
      if (cfg_we) begin
        rx_id_r <= cfg_wdata;
      end
      if (accept && match) begin
        asm_r <= asm_nxt;
        exp_r <= exp_nxt;
        rc_r  <= rc_nxt;
        seq_r <= seq_nxt;
      end
    end
  end

endmodule

// ----- rtl/isotp_cmdq.sv -----
// Short command queue between front end and back end.
// Depends on isotp_pkg.
module isotp_cmdq import isotp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             entry_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/isotp_back.sv -----
// Back end: message store writes, completion read-out and output register.
// Depends on isotp_pkg and isotp_frame_reassembler_assert.svh.
`include "isotp_frame_reassembler_assert.svh"
module isotp_back import isotp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int WIDX_W = POS_W - 3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WR0   = 5'b00010,
    ST_WR1   = 5'b00100,
    ST_RADDR = 5'b01000,
    ST_RDATA = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic              cmd_ld;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [POS_W-1:0]  rem_r, rem_nxt;
  logic [63:0]       rdata_r;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;

  logic [63:0]       mem [STORE_WORDS];

  logic              slot_free;
  logic              load;
  out_t              load_data;
  logic [2:0]        off;
  logic [WIDX_W-1:0] word0, word1;
  logic [127:0]      wide;
  logic [15:0]       be16;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [63:0]       wr_data;
  logic [7:0]        wr_be;
  logic              rd_en;
  logic [3:0]        rd_vb;
  logic              rd_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign off       = cmd_r.pos[2:0];
  assign word0     = cmd_r.pos[POS_W-1:3];
  assign word1     = WIDX_W'(word0 + 1'b1);
  assign wide      = {cmd_r.res.data_word, 64'h0} >> {off, 3'b000};
  assign be16      = {top_be(cmd_r.res.valid_bytes), 8'h00} >> off;
  assign rd_vb     = (rem_r >= POS_W'(8)) ? 4'd8 : rem_r[3:0];
  assign rd_last   = (rem_r <= POS_W'(8));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    cmd_ld    = 1'b0;
    load      = 1'b0;
    load_data = '0;
    wr_en     = 1'b0;
    wr_addr   = ADDR_W'(word0);
    wr_data   = wide[127:64];
    wr_be     = be16[15:8];
    rd_en     = 1'b0;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == CMD_REPORT) begin
            if (slot_free) begin
              q_pop     = 1'b1;
              load      = 1'b1;
              load_data = q_cmd.res;
            end
          end else begin
            q_pop     = 1'b1;
            cmd_ld    = 1'b1;
            state_nxt = ST_WR0;
          end
        end
      end
      ST_WR0: begin
        wr_en     = (int'(word0) < STORE_WORDS);
        state_nxt = ST_WR1;
      end
      ST_WR1: begin
        wr_en   = (int'(word1) < STORE_WORDS) && (be16[7:0] != 8'h00);
        wr_addr = ADDR_W'(word1);
        wr_data = wide[63:0];
        wr_be   = be16[7:0];
        if (cmd_r.op == CMD_STORE_LAST) begin
          k_nxt     = '0;
          rem_nxt   = POS_W'(cmd_r.res.msg_length);
          state_nxt = ST_RADDR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RADDR: begin
        rd_en     = 1'b1;
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        if (slot_free) begin
          load                  = 1'b1;
          load_data.kind        = KIND_DATA;
          load_data.data_word   = rdata_r & top_mask(rd_vb);
          load_data.valid_bytes = rd_vb;
          load_data.last        = rd_last;
          load_data.msg_length  = cmd_r.res.msg_length;
          k_nxt                 = ADDR_W'(k_r + 1'b1);
          rem_nxt               = rem_r - POS_W'(8);
          state_nxt             = rd_last ? ST_IDLE : ST_RADDR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ld) begin
      cmd_r <= q_cmd;
    end
    if (load) begin
      out_data_r <= load_data;
    end
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < 8; b++) begin
        if (wr_be[b]) begin
          mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[k_r];
    end
  end

  `ISOTP_ASSERT_NXT(a_wr0_then_wr1, state_r == ST_WR0, state_r == ST_WR1, "store skipped second word")
  `ISOTP_ASSERT_IMP(a_load_slot_free, load, !out_valid_r || !out_stall, "output overwritten")
  `ISOTP_ASSERT_IMP(a_readout_nonempty, state_r == ST_RDATA || state_r == ST_RADDR, rem_r != '0, "read-out past message end")
  `ISOTP_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty queue")

endmodule

// ----- rtl/isotp_frame_reassembler.sv -----
// Top level of the ISO-TP frame reassembler: front end, command queue, back end.
// Depends on isotp_pkg, isotp_front, isotp_cmdq and isotp_back.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------
//   in      | in_valid / in_stall    | in_data  (can_id, payload)
//   out     | out_valid / out_stall  | out_data (kind ... st_min)
//   cfg     | cfg_we                 | cfg_wdata (rx_id)
//
// A frame is decoded in the cycle it is taken; in_stall rises only when the
// 4-entry command queue is full. The back end handles a report in ST_IDLE and a
// store command in ST_WR0 and ST_WR1; completion reads the message store word by
// word through ST_RADDR and ST_RDATA and waits there while the output is stalled.
// Reset is synchronous; the message store needs no clearing pass.
module isotp_frame_reassembler import isotp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  isotp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  isotp_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  isotp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/isotp_frame_reassembler_chk.sv -----
`timescale 1ns / 1ps
// Scoreboard for isotp_frame_reassembler: watches the rx_id, frame and result ports,
// rebuilds every message from the accepted frames and compares results in order.
// Depends on isotp_pkg.
module isotp_frame_reassembler_chk import isotp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  output int          pending,
  output int          faults,
  output int          checked
);

  logic [10:0] rx_id_q = '0;
  logic        busy = 1'b0;
  logic [11:0] want_len = '0;
  logic [12:0] got_len = '0;
  logic [3:0]  seq_q = '0;
  logic [63:0] msg_words [STORE_WORDS];
  out_t        due_results [$];
  int          n_faults = 0;
  int          n_checked = 0;

  function automatic logic [63:0] keep_top(input int unsigned nbytes);
    return ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * nbytes));
  endfunction

  function automatic void put_byte(input int unsigned pos, input logic [7:0] b);
    if (pos < MAX_LEN) msg_words[pos / 8][8 * (7 - pos % 8) +: 8] = b;
  endfunction

  function automatic void add_due(input out_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic bit differs(input out_t a, input out_t b);
    return a.kind !== b.kind || a.data_word !== b.data_word
        || a.valid_bytes !== b.valid_bytes || a.last !== b.last
        || a.msg_length !== b.msg_length || a.flow_status !== b.flow_status
        || a.block_size !== b.block_size || a.st_min !== b.st_min;
  endfunction

  task automatic flag(input string what, input out_t want, input out_t seen);
    n_faults++;
    if (n_faults <= 10) begin
      $display("%t %s (expected / actual):", $time, what);
      $display("  kind %0d/%0d data %h/%h bytes %0d/%0d last %0d/%0d",
               want.kind, seen.kind, want.data_word, seen.data_word,
               want.valid_bytes, seen.valid_bytes, want.last, seen.last);
      $display("  len %0d/%0d status %0d/%0d bs %h/%h st %h/%h",
               want.msg_length, seen.msg_length, want.flow_status, seen.flow_status,
               want.block_size, seen.block_size, want.st_min, seen.st_min);
    end
  endtask

  task automatic decode_frame(input in_t f);
    logic [3:0]  ftype;
    logic [3:0]  low;
    int unsigned total;
    int unsigned n;
    int unsigned vb;
    out_t        r;
    ftype = f.payload[63:60];
    low   = f.payload[59:56];
    r     = '0;
    if (f.can_id != rx_id_q) return;
    case (ftype)
      FT_SINGLE: begin
        if (low == 4'd0 || low > 4'd7) return;
        r.kind        = KIND_DATA;
        r.data_word   = (f.payload << 8) & keep_top(low);
        r.valid_bytes = low;
        r.last        = 1'b1;
        r.msg_length  = LEN_W'(low);
        add_due(r);
      end
      FT_FIRST: begin
        total = {low, f.payload[55:48]};
        if (total > MAX_LEN) begin
          busy         = 1'b0;
          r.kind       = KIND_TOO_LONG;
          r.last       = 1'b1;
          r.msg_length = LEN_W'(total);
          add_due(r);
          return;
        end
        if (total < 8) return;
        for (int i = 0; i < FF_BYTES; i++) put_byte(i, f.payload[47 - 8 * i -: 8]);
        busy     = 1'b1;
        want_len = 12'(total);
        got_len  = 13'(FF_BYTES);
        seq_q    = '0;
      end
      FT_CONSEC: begin
        if (!busy) return;
        if (low != 4'(seq_q + 4'd1)) return;
        seq_q = low;
        for (int i = 0; i < CF_BYTES; i++) put_byte(got_len + i, f.payload[55 - 8 * i -: 8]);
        got_len = got_len + 13'(CF_BYTES);
        if (got_len < want_len) return;
        n = (want_len + 7) / 8;
        for (int k = 0; k < n; k++) begin
          vb = want_len - 8 * k;
          if (vb > 8) vb = 8;
          r             = '0;
          r.kind        = KIND_DATA;
          r.data_word   = msg_words[k] & keep_top(vb);
          r.valid_bytes = 4'(vb);
          r.last        = (k + 1 == n);
          r.msg_length  = want_len;
          add_due(r);
        end
        busy     = 1'b0;
        want_len = '0;
        got_len  = '0;
        seq_q    = '0;
      end
      FT_FLOW: begin
        r.kind        = KIND_FLOW;
        r.last        = 1'b1;
        r.flow_status = (low > 4'd3) ? 2'd3 : low[1:0];
        r.block_size  = f.payload[55:48];
        r.st_min      = f.payload[47:40];
        add_due(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      rx_id_q  = '0;
      busy     = 1'b0;
      want_len = '0;
      got_len  = '0;
      seq_q    = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (due_results.size() == 0) begin
          flag("result with nothing due", '0, out_data);
        end else begin
          want = due_results.pop_front();
          if (differs(want, out_data)) flag("result mismatch", want, out_data);
        end
      end
      if (cfg_we) rx_id_q = cfg_wdata;
      if (in_valid && !in_stall) decode_frame(in_data);
    end
    pending <= due_results.size();
    faults  <= n_faults;
    checked <= n_checked;
  end

endmodule

// ----- bench/isotp_frame_reassembler_tb.sv -----
`timescale 1ns / 1ps
// Top of the isotp_frame_reassembler bench: clock, reset, rx_id writes, CAN frame
// stimulus and result back-pressure. Depends on isotp_pkg, the RTL top and
// isotp_frame_reassembler_chk, which does all checking.
module isotp_frame_reassembler_tb;
  import isotp_pkg::*;

  localparam int LIMIT  = 2_000_000;
  localparam int SETTLE = 64;
  localparam int QUOTA  = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  int          pending;
  int          faults;
  int          checked;
  int          cycles = 0;
  logic [10:0] rx = '0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          frames_sent = 0;
  int          useful = 0;
  int          messages = 0;
  int          id_writes = 0;

  isotp_frame_reassembler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  isotp_frame_reassembler_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pending   (pending),
    .faults    (faults),
    .checked   (checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [10:0] foreign_id();
    logic [10:0] id;
    id = 11'($urandom_range(0, 2047));
    if (id == rx) id = ~rx;
    return id;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(8, 48);
    if (r < 92) return $urandom_range(49, 200);
    if (r < 98) return $urandom_range(201, MAX_LEN - 1);
    return MAX_LEN;
  endfunction

  task automatic send_frame(input logic [10:0] id, input logic [63:0] p);
    int  gap;
    in_t f;
    gap       = tx_calm ? 0 : $urandom_range(0, 6);
    f.can_id  = id;
    f.payload = p;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
    frames_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rx_id(input logic [10:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    rx = v;
    id_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(input int len);
    logic [3:0]  seq;
    logic [63:0] p;
    int          sent;
    int          r;
    messages++;
    p = rnd64();
    p[63:48] = {FT_FIRST, 12'(len)};
    send_frame(rx, p);
    useful++;
    seq  = 4'd1;
    sent = FF_BYTES;
    while (sent < len) begin
      r = $urandom_range(0, 99);
      if (r < 2) return;
      p = rnd64();
      if (r < 5) begin
        p[63:56] = {FT_CONSEC, seq + 4'($urandom_range(1, 15))};
        send_frame(rx, p);
      end else if (r < 8) begin
        send_frame(foreign_id(), p);
      end else if (r < 10) begin
        p[63:60] = FT_FLOW;
        send_frame(rx, p);
        useful++;
      end
      p = rnd64();
      p[63:56] = {FT_CONSEC, seq};
      send_frame(rx, p);
      useful++;
      seq++;
      sent += CF_BYTES;
    end
  endtask

  task automatic random_phase(input int quota);
    int          stop;
    int          r;
    int          n;
    logic [63:0] p;
    stop = useful + quota;
    while (useful < stop) begin
      if ($urandom_range(0, 7) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 7) == 0) rx_calm = ~rx_calm;
      r = $urandom_range(0, 99);
      p = rnd64();
      if (r < 50) begin
        send_message(pick_len());
      end else if (r < 62) begin
        n = $urandom_range(0, 15);
        p[63:56] = {FT_SINGLE, 4'(n)};
        send_frame(rx, p);
        if (n >= 1 && n <= 7) useful++;
      end else if (r < 70) begin
        p[63:60] = FT_FLOW;
        send_frame(rx, p);
        useful++;
      end else if (r < 75) begin
        p[63:48] = {FT_FIRST, 12'($urandom_range(MAX_LEN + 1, 4095))};
        send_frame(rx, p);
        useful++;
      end else if (r < 79) begin
        p[63:48] = {FT_FIRST, 12'($urandom_range(0, 7))};
        send_frame(rx, p);
      end else if (r < 87) begin
        send_frame(foreign_id(), p);
      end else if (r < 93) begin
        p[63:56] = {FT_CONSEC, 4'($urandom_range(0, 15))};
        send_frame(rx, p);
      end else begin
        send_frame(rx, p);
      end
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("isotp_frame_reassembler_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(rx, 64'h01A5_FFFF_FFFF_FFFF);
    send_frame(rx, 64'h07FF_FFFF_FFFF_FFFF);
    send_frame(rx, 64'h0011_2233_4455_6677);  // SF length 0, dropped
    send_frame(rx, 64'h08FF_FFFF_FFFF_FFFF);  // SF length 8, dropped
    send_frame(rx, 64'h2112_3456_789A_BCDE);  // CF with nothing open
    send_frame(rx, 64'h1007_0102_0304_0506);  // FF shorter than 8
    send_frame(rx, 64'h1FFF_0000_0000_0000);  // largest announced length
    send_frame(rx, 64'h1008_0102_0304_0506);
    send_frame(rx, 64'h2107_08AA_BBCC_DDEE);
    send_frame(rx, 64'h1014_1011_1213_1415);
    send_frame(rx, 64'h2399_9999_9999_9999);  // out of sequence
    send_frame(rx, 64'h2116_1718_191A_1B1C);
    send_frame(rx, 64'h221D_1E1F_2021_2223);
    send_frame(rx, 64'h101E_3031_3233_3435);  // restarted below
    send_frame(rx, 64'h1009_4041_4243_4445);
    send_frame(rx, 64'h2146_4748_0000_0000);
    send_frame(rx, 64'h1014_5051_5253_5455);
    send_frame(rx, 64'h2156_5758_595A_5B5C);
    send_frame(rx, 64'h1258_0000_0000_0000);  // oversized FF drops open message
    send_frame(rx, 64'h225D_5E5F_6061_6263);
    send_frame(rx, 64'h3000_FF00_0000_0000);
    send_frame(rx, 64'h3101_7F00_0000_0000);
    send_frame(rx, 64'h3200_00FF_0000_0000);
    send_frame(rx, 64'h3F80_0000_0000_0000);  // status above 3 reads reserved
    send_frame(rx, 64'hF123_4567_89AB_CDEF);
    send_frame(11'h7FF, 64'h0155_0000_0000_0000);
    drain();

    set_rx_id(11'h7FF);
    random_phase(QUOTA);
    set_rx_id(11'($urandom_range(1, 2046)));
    random_phase(QUOTA);
    set_rx_id(11'h000);
    random_phase(QUOTA);
    set_rx_id(11'($urandom_range(1, 2046)));
    random_phase(QUOTA);
    set_rx_id(11'($urandom_range(1, 2046)));
    random_phase(QUOTA);
    drain();

    $display("sent %0d frames (%0d messages started), checked %0d results",
             frames_sent, messages, checked);
    $display("rx_id set %0d times; directed cases, then random traffic with stalls",
             id_writes);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (faults == 0 && pending == 0) begin
      $display("isotp_frame_reassembler_tb: done, clean");
    end else begin
      $display("isotp_frame_reassembler_tb: done, errors");
    end
    $finish;
  end

endmodule
